@@ src/html_tag_strip_entity_decode_assert.svh @@
// assertion macros shared by the html cleaner modules
// both sample on clk; the first one is masked while arst_n is low
`ifndef HTML_TAG_STRIP_ENTITY_DECODE_ASSERT_SVH
`define HTML_TAG_STRIP_ENTITY_DECODE_ASSERT_SVH

// checked only out of reset
`define HTSED_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define HTSED_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/htsed_pkg.sv @@
`default_nettype none

package htsed_pkg;

	// sizes
	localparam int NodeCount  = 20;
	localparam int NodeW      = 5;
	localparam int MaxChars   = 7;
	localparam int CharCntW   = 3;
	localparam int QueueDepth = 4;
	localparam int QueuePtrW  = 2;
	localparam int QueueCntW  = 3;

	// special characters
	localparam logic [7:0] ChTagOpen  = 8'h3C;
	localparam logic [7:0] ChTagClose = 8'h3E;
	localparam logic [7:0] ChAmp      = 8'h26;
	localparam logic [7:0] ChSpace    = 8'h20;
	localparam logic [7:0] ChTab      = 8'h09;
	localparam logic [7:0] ChNewline  = 8'h0A;

	// trie nodes, each names the prefix seen so far
	localparam logic [NodeW-1:0] NodeNone  = 5'd0;
	localparam logic [NodeW-1:0] NodeAmp   = 5'd1;
	localparam logic [NodeW-1:0] NodeA     = 5'd2;
	localparam logic [NodeW-1:0] NodeAm    = 5'd3;
	localparam logic [NodeW-1:0] NodeL     = 5'd4;
	localparam logic [NodeW-1:0] NodeG     = 5'd5;
	localparam logic [NodeW-1:0] NodeQ     = 5'd6;
	localparam logic [NodeW-1:0] NodeQu    = 5'd7;
	localparam logic [NodeW-1:0] NodeQuo   = 5'd8;
	localparam logic [NodeW-1:0] NodeHash  = 5'd9;
	localparam logic [NodeW-1:0] NodeHash3 = 5'd10;
	localparam logic [NodeW-1:0] NodeN     = 5'd11;
	localparam logic [NodeW-1:0] NodeNb    = 5'd12;
	localparam logic [NodeW-1:0] NodeNbs   = 5'd13;
	localparam logic [NodeW-1:0] NodeAmpP  = 5'd14;
	localparam logic [NodeW-1:0] NodeLt    = 5'd15;
	localparam logic [NodeW-1:0] NodeGt    = 5'd16;
	localparam logic [NodeW-1:0] NodeQuot  = 5'd17;
	localparam logic [NodeW-1:0] NodeH39   = 5'd18;
	localparam logic [NodeW-1:0] NodeNbsp  = 5'd19;

	// channel words
	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       end_of_text;
	} out_word_t;

	// everything one input byte produces, queued between front and back
	typedef struct packed {
		logic [0:MaxChars-1][7:0] chars;
		logic [CharCntW-1:0]      char_cnt;
		logic                     eot;
	} group_t;

	// literal text of an open prefix
	typedef struct packed {
		logic [0:MaxChars-1][7:0] chars;
		logic [CharCntW-1:0]      len;
	} text_t;

	// one trie step; to of NodeNone means the entity is complete
	typedef struct packed {
		logic             hit;
		logic [NodeW-1:0] to;
		logic [7:0]       decoded;
	} trie_step_t;

	function automatic text_t node_text(input logic [NodeW-1:0] node);
		text_t t;
		t.chars = '0;
		t.len   = 3'd0;
		case (node)
			NodeAmp:   begin t.chars = {"&",     48'h0}; t.len = 3'd1; end
			NodeA:     begin t.chars = {"&a",    40'h0}; t.len = 3'd2; end
			NodeAm:    begin t.chars = {"&am",   32'h0}; t.len = 3'd3; end
			NodeL:     begin t.chars = {"&l",    40'h0}; t.len = 3'd2; end
			NodeG:     begin t.chars = {"&g",    40'h0}; t.len = 3'd2; end
			NodeQ:     begin t.chars = {"&q",    40'h0}; t.len = 3'd2; end
			NodeQu:    begin t.chars = {"&qu",   32'h0}; t.len = 3'd3; end
			NodeQuo:   begin t.chars = {"&quo",  24'h0}; t.len = 3'd4; end
			NodeHash:  begin t.chars = {"&#",    40'h0}; t.len = 3'd2; end
			NodeHash3: begin t.chars = {"&#3",   32'h0}; t.len = 3'd3; end
			NodeN:     begin t.chars = {"&n",    40'h0}; t.len = 3'd2; end
			NodeNb:    begin t.chars = {"&nb",   32'h0}; t.len = 3'd3; end
			NodeNbs:   begin t.chars = {"&nbs",  24'h0}; t.len = 3'd4; end
			NodeAmpP:  begin t.chars = {"&amp",  24'h0}; t.len = 3'd4; end
			NodeLt:    begin t.chars = {"&lt",   32'h0}; t.len = 3'd3; end
			NodeGt:    begin t.chars = {"&gt",   32'h0}; t.len = 3'd3; end
			NodeQuot:  begin t.chars = {"&quot", 16'h0}; t.len = 3'd5; end
			NodeH39:   begin t.chars = {"&#39",  24'h0}; t.len = 3'd4; end
			NodeNbsp:  begin t.chars = {"&nbsp", 16'h0}; t.len = 3'd5; end
			default:   begin t.chars = '0;              t.len = 3'd0; end
		endcase
		return t;
	endfunction

	function automatic trie_step_t trie_step(input logic [NodeW-1:0] node,
						 input logic [7:0] b);
		trie_step_t s;
		s = '0;
		case (node)
			NodeAmp: begin
				if (b == "a")      begin s.hit = 1'b1; s.to = NodeA;     end
				else if (b == "l") begin s.hit = 1'b1; s.to = NodeL;     end
				else if (b == "g") begin s.hit = 1'b1; s.to = NodeG;     end
				else if (b == "q") begin s.hit = 1'b1; s.to = NodeQ;     end
				else if (b == "#") begin s.hit = 1'b1; s.to = NodeHash;  end
				else if (b == "n") begin s.hit = 1'b1; s.to = NodeN;     end
			end
			NodeA:     if (b == "m") begin s.hit = 1'b1; s.to = NodeAm;    end
			NodeAm:    if (b == "p") begin s.hit = 1'b1; s.to = NodeAmpP;  end
			NodeL:     if (b == "t") begin s.hit = 1'b1; s.to = NodeLt;    end
			NodeG:     if (b == "t") begin s.hit = 1'b1; s.to = NodeGt;    end
			NodeQ:     if (b == "u") begin s.hit = 1'b1; s.to = NodeQu;    end
			NodeQu:    if (b == "o") begin s.hit = 1'b1; s.to = NodeQuo;   end
			NodeQuo:   if (b == "t") begin s.hit = 1'b1; s.to = NodeQuot;  end
			NodeHash:  if (b == "3") begin s.hit = 1'b1; s.to = NodeHash3; end
			NodeHash3: if (b == "9") begin s.hit = 1'b1; s.to = NodeH39;   end
			NodeN:     if (b == "b") begin s.hit = 1'b1; s.to = NodeNb;    end
			NodeNb:    if (b == "s") begin s.hit = 1'b1; s.to = NodeNbs;   end
			NodeNbs:   if (b == "p") begin s.hit = 1'b1; s.to = NodeNbsp;  end
			NodeAmpP:  if (b == ";") begin s.hit = 1'b1; s.decoded = ChAmp;      end
			NodeLt:    if (b == ";") begin s.hit = 1'b1; s.decoded = ChTagOpen;  end
			NodeGt:    if (b == ";") begin s.hit = 1'b1; s.decoded = ChTagClose; end
			NodeQuot:  if (b == ";") begin s.hit = 1'b1; s.decoded = 8'h22;      end
			NodeH39:   if (b == ";") begin s.hit = 1'b1; s.decoded = 8'h27;      end
			NodeNbsp:  if (b == ";") begin s.hit = 1'b1; s.decoded = ChSpace;    end
			default:   s = '0;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

@@ src/htsed_front.sv @@
`default_nettype none

module htsed_front import htsed_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     fire,
	input  wire in_word_t word,
	output group_t        grp,
	output logic          grp_push
);

	logic             inside_tag_q;
	logic [NodeW-1:0] entity_node_q;
	logic             wrote_any_q;
	logic             space_pending_q;

	logic             tag_n;
	logic [NodeW-1:0] node_n;
	logic             wrote_n;
	logic             pend_n;
	logic [NodeW-1:0] node_v;
	logic [NodeW-1:0] t_node;
	logic             have_x;
	logic [7:0]       x_byte;
	logic             x_space;
	logic             x_emit;
	logic             t_any;
	logic             lead;
	logic             wrote1;
	logic             pend1;
	text_t            tx;
	trie_step_t       st;

	// classify the byte: literal prefix text, then at most one more character
	always_comb begin
		node_v = (entity_node_q >= NodeW'(NodeCount)) ? NodeNone : entity_node_q;
		st     = trie_step(node_v, word.in_byte);
		tag_n  = inside_tag_q;
		node_n = node_v;
		t_node = NodeNone;
		have_x = 1'b0;
		x_byte = word.in_byte;
		if (inside_tag_q) begin
			if (word.in_byte == ChTagClose) tag_n = 1'b0;
		end else if (node_v != NodeNone && st.hit) begin
			if (st.to != NodeNone) begin
				node_n = st.to;
			end else begin
				node_n = NodeNone;
				have_x = 1'b1;
				x_byte = st.decoded;
			end
		end else begin
			// failed prefix goes out literally, then the byte is plain
			t_node = node_v;
			node_n = NodeNone;
			if (word.in_byte == ChTagOpen) tag_n = 1'b1;
			else if (word.in_byte == ChAmp) node_n = NodeAmp;
			else have_x = 1'b1;
		end
		// end of text flushes a still open prefix
		if (word.last_byte && node_n != NodeNone) begin
			if (t_node == NodeNone) begin
				t_node = node_n;
			end else begin
				have_x = 1'b1;
				x_byte = ChAmp;
			end
		end
	end

	// space folding and layout of the characters
	always_comb begin
		tx      = node_text(t_node);
		t_any   = (tx.len != 3'd0);
		x_space = have_x && (x_byte == ChSpace || x_byte == ChTab || x_byte == ChNewline);
		x_emit  = have_x && !x_space;
		lead    = space_pending_q && (t_any || x_emit);
		wrote1  = wrote_any_q || t_any;
		pend1   = t_any ? 1'b0 : space_pending_q;
		wrote_n = wrote1 || x_emit;
		pend_n  = x_emit ? 1'b0 : (x_space ? (pend1 || wrote1) : pend1);
		grp.chars    = '0;
		grp.char_cnt = CharCntW'(lead) + tx.len + CharCntW'(x_emit);
		grp.eot      = word.last_byte;
		for (int i = 0; i < MaxChars; i++) begin
			logic [CharCntW-1:0] j;
			j = CharCntW'(i) - CharCntW'(lead);
			if (lead && i == 0) grp.chars[i] = ChSpace;
			else if (j < tx.len) grp.chars[i] = tx.chars[j];
			else if (j == tx.len && x_emit) grp.chars[i] = x_byte;
		end
		grp_push = fire && (grp.char_cnt != '0 || grp.eot);
	end

	// text state, cleared at end of text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_tag_q    <= 1'b0;
			entity_node_q   <= NodeNone;
			wrote_any_q     <= 1'b0;
			space_pending_q <= 1'b0;
		end else if (fire) begin
			if (word.last_byte) begin
				inside_tag_q    <= 1'b0;
				entity_node_q   <= NodeNone;
				wrote_any_q     <= 1'b0;
				space_pending_q <= 1'b0;
			end else begin
				inside_tag_q    <= tag_n;
				entity_node_q   <= node_n;
				wrote_any_q     <= wrote_n;
				space_pending_q <= pend_n;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/htsed_queue.sv @@
`default_nettype none

module htsed_queue import htsed_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire group_t push_grp,
	input  wire logic   pop,
	output group_t      head,
	output logic        head_valid,
	output logic        full
);

	group_t                entries_q [QueueDepth];
	logic [QueuePtrW-1:0]  wr_ptr_q;
	logic [QueuePtrW-1:0]  rd_ptr_q;
	logic [QueueCntW-1:0]  count_q;

	assign head       = entries_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign full       = (count_q == QueueCntW'(QueueDepth));

	// group storage
	always_ff @(posedge clk) begin
		if (push) entries_q[wr_ptr_q] <= push_grp;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

`include "html_tag_strip_entity_decode_assert.svh"

	`HTSED_ASSERT(a_no_push_full, push |-> !full, "push into full queue")
	`HTSED_ASSERT(a_no_pop_empty, pop |-> head_valid, "pop from empty queue")
	`HTSED_ASSERT(a_count_bound, count_q <= QueueCntW'(QueueDepth), "queue count overrun")

endmodule

`default_nettype wire

@@ src/htsed_back.sv @@
`default_nettype none

module htsed_back import htsed_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire group_t head,
	input  wire logic   head_valid,
	output logic        pop,
	output logic        clean_valid,
	input  wire logic   clean_stall,
	output out_word_t   clean
);

	logic [CharCntW-1:0] idx_q;
	logic                valid_q;
	out_word_t           word_q;
	out_word_t           next_word;
	logic                last_word;
	logic                load;

	// pick the word at the current position of the head group
	always_comb begin
		next_word = '0;
		if (idx_q < head.char_cnt) begin
			next_word.out_byte   = head.chars[idx_q];
			next_word.byte_valid = 1'b1;
		end else begin
			next_word.end_of_text = 1'b1;
		end
		last_word = head.eot ? (idx_q == head.char_cnt)
				     : ({1'b0, idx_q} + 4'd1 == {1'b0, head.char_cnt});
		load = head_valid && (!valid_q || !clean_stall);
		pop  = load && last_word;
	end

	// output register and position in the group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= last_word ? '0 : idx_q + 1'b1;
		end else if (!clean_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) word_q <= next_word;
	end

	assign clean_valid = valid_q;
	assign clean       = word_q;

`include "html_tag_strip_entity_decode_assert.svh"

	`HTSED_ASSERT(a_idx_in_group, head_valid |-> idx_q <= head.char_cnt, "index past group")
	`HTSED_ASSERT(a_idx_idle, !head_valid |-> idx_q == '0, "index left over with no group")
	`HTSED_ASSERT(a_pop_when_load, pop |-> load && head_valid, "pop without a word")

endmodule

`default_nettype wire

@@ src/html_tag_strip_entity_decode.sv @@
// HTML text cleaner: strips tags, decodes six entities, folds white space.
// Input channel text: one byte per word with last_byte on the final byte of
// a text; a word is taken at a rising edge with text_valid high and
// text_stall low. Output channel clean: one cleaned byte per word
// (byte_valid 1), and one end word (end_of_text 1, byte 0) after the last
// byte of each text; taken when clean_valid is high and clean_stall low.
// An input byte gives 0 to 8 output words. The front takes one byte per
// cycle and classifies it in that cycle; the words it makes are queued as
// one group in a four-entry queue. The back sends one word per cycle from
// that queue; the first word of a byte passes the queue and then the
// output register. Sustained input rate is one byte per cycle while output
// words keep pace; a long burst (failed entity prefix) drains at one word
// per cycle and text_stall rises once the queue holds four groups.
// While clean_stall is high the output word holds, the queue fills, and
// then text_stall stops the input. Reset empties the queue and output and
// clears the tag, entity, and space state; end of text clears them too.
`default_nettype none

module html_tag_strip_entity_decode import htsed_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     text_valid,
	output logic          text_stall,
	input  wire in_word_t text,
	output logic          clean_valid,
	input  wire logic     clean_stall,
	output out_word_t     clean
);

	logic   fire;
	logic   grp_push;
	group_t grp;
	group_t head;
	logic   head_valid;
	logic   pop;
	logic   full;

	assign text_stall = full;
	assign fire       = text_valid && !text_stall;

	// classify bytes
	htsed_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.word     (text),
		.grp      (grp),
		.grp_push (grp_push)
	);

	// group queue between front and back
	htsed_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (grp_push),
		.push_grp   (grp),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (full)
	);

	// send words
	htsed_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (head_valid),
		.pop         (pop),
		.clean_valid (clean_valid),
		.clean_stall (clean_stall),
		.clean       (clean)
	);

endmodule

`default_nettype wire

@@ test/html_tag_strip_entity_decode_checker.sv @@
module html_tag_strip_entity_decode_checker import htsed_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      text_valid,
	input  wire logic      text_stall,
	input  wire in_word_t  text,
	input  wire logic      clean_valid,
	input  wire logic      clean_stall,
	input  wire out_word_t clean,
	output int             errors,
	output int             outstanding,
	output int             bytes_taken,
	output int             words_taken,
	output int             texts_taken
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         MaxWords  = 8;
	localparam int         MaxPrints = 40;
	localparam logic [7:0] ChQuote   = 8'h22;
	localparam logic [7:0] ChApos    = 8'h27;

	// cleaner state as the predictor sees it
	logic             in_tag      = 1'b0;
	logic [NodeW-1:0] prefix_node = NodeNone;
	logic             seen_char   = 1'b0;
	logic             held_space  = 1'b0;

	// predicted clean words, oldest first
	out_word_t clean_q[$];
	int        burst_len = 0;
	int        fail_cnt  = 0;
	int        byte_cnt  = 0;
	int        word_cnt  = 0;
	int        text_cnt  = 0;

	// literal text of an open entity prefix
	function automatic string prefix_literal(input logic [NodeW-1:0] node);
		case (node)
			NodeAmp:   return "&";
			NodeA:     return "&a";
			NodeAm:    return "&am";
			NodeL:     return "&l";
			NodeG:     return "&g";
			NodeQ:     return "&q";
			NodeQu:    return "&qu";
			NodeQuo:   return "&quo";
			NodeHash:  return "&#";
			NodeHash3: return "&#3";
			NodeN:     return "&n";
			NodeNb:    return "&nb";
			NodeNbs:   return "&nbs";
			NodeAmpP:  return "&amp";
			NodeLt:    return "&lt";
			NodeGt:    return "&gt";
			NodeQuot:  return "&quot";
			NodeH39:   return "&#39";
			NodeNbsp:  return "&nbsp";
			default:   return "";
		endcase
	endfunction

	// one step down the entity trie; nxt of none with a hit means decoded
	task automatic trie_walk(input logic [NodeW-1:0] node, input logic [7:0] b,
			output logic hit, output logic [NodeW-1:0] nxt, output logic [7:0] dec);
		hit = 1'b0;
		nxt = NodeNone;
		dec = 8'h00;
		case (node)
			NodeAmp: begin
				hit = 1'b1;
				case (b)
					"a":     nxt = NodeA;
					"l":     nxt = NodeL;
					"g":     nxt = NodeG;
					"q":     nxt = NodeQ;
					"#":     nxt = NodeHash;
					"n":     nxt = NodeN;
					default: hit = 1'b0;
				endcase
			end
			NodeA:     begin hit = (b == "m"); nxt = NodeAm;    end
			NodeAm:    begin hit = (b == "p"); nxt = NodeAmpP;  end
			NodeL:     begin hit = (b == "t"); nxt = NodeLt;    end
			NodeG:     begin hit = (b == "t"); nxt = NodeGt;    end
			NodeQ:     begin hit = (b == "u"); nxt = NodeQu;    end
			NodeQu:    begin hit = (b == "o"); nxt = NodeQuo;   end
			NodeQuo:   begin hit = (b == "t"); nxt = NodeQuot;  end
			NodeHash:  begin hit = (b == "3"); nxt = NodeHash3; end
			NodeHash3: begin hit = (b == "9"); nxt = NodeH39;   end
			NodeN:     begin hit = (b == "b"); nxt = NodeNb;    end
			NodeNb:    begin hit = (b == "s"); nxt = NodeNbs;   end
			NodeNbs:   begin hit = (b == "p"); nxt = NodeNbsp;  end
			NodeAmpP:  begin hit = (b == ";"); dec = ChAmp;      end
			NodeLt:    begin hit = (b == ";"); dec = ChTagOpen;  end
			NodeGt:    begin hit = (b == ";"); dec = ChTagClose; end
			NodeQuot:  begin hit = (b == ";"); dec = ChQuote;    end
			NodeH39:   begin hit = (b == ";"); dec = ChApos;     end
			NodeNbsp:  begin hit = (b == ";"); dec = ChSpace;    end
			default:   hit = 1'b0;
		endcase
	endtask

	// at most eight words per input byte
	task automatic queue_word(input logic [7:0] c, input logic v, input logic e);
		out_word_t w;
		w.out_byte    = c;
		w.byte_valid  = v;
		w.end_of_text = e;
		if (burst_len < MaxWords) begin
			clean_q.push_back(w);
			burst_len++;
		end
	endtask

	// white space folds into one held space, dropped at the start of a text
	task automatic emit_char(input logic [7:0] c);
		if (c == ChSpace || c == ChTab || c == ChNewline) begin
			if (seen_char)
				held_space = 1'b1;
		end else begin
			if (held_space)
				queue_word(ChSpace, 1'b1, 1'b0);
			held_space = 1'b0;
			queue_word(c, 1'b1, 1'b0);
			seen_char = 1'b1;
		end
	endtask

	task automatic flush_prefix_text();
		string lit;
		int    i;
		lit = prefix_literal(prefix_node);
		prefix_node = NodeNone;
		for (i = 0; i < lit.len(); i++)
			emit_char(lit[i]);
	endtask

	task automatic take_plain(input logic [7:0] b);
		if (b == ChTagOpen)
			in_tag = 1'b1;
		else if (b == ChAmp)
			prefix_node = NodeAmp;
		else
			emit_char(b);
	endtask

	task automatic clear_state();
		in_tag      = 1'b0;
		prefix_node = NodeNone;
		seen_char   = 1'b0;
		held_space  = 1'b0;
	endtask

	// all clean words that one text byte causes
	task automatic predict_byte(input in_word_t w);
		logic             hit;
		logic [NodeW-1:0] nxt;
		logic [7:0]       dec;
		burst_len = 0;
		if (prefix_node >= NodeCount)
			prefix_node = NodeNone;
		if (in_tag) begin
			if (w.in_byte == ChTagClose)
				in_tag = 1'b0;
		end else if (prefix_node != NodeNone) begin
			trie_walk(prefix_node, w.in_byte, hit, nxt, dec);
			if (!hit) begin
				flush_prefix_text();
				take_plain(w.in_byte);
			end else if (nxt != NodeNone) begin
				prefix_node = nxt;
			end else begin
				prefix_node = NodeNone;
				emit_char(dec);
			end
		end else begin
			take_plain(w.in_byte);
		end
		// end of text: spill an open prefix, mark the end, start over
		if (w.last_byte) begin
			if (prefix_node != NodeNone)
				flush_prefix_text();
			queue_word(8'h00, 1'b0, 1'b1);
			clear_state();
		end
	endtask

	task automatic report(input string field, input logic [7:0] want, input logic [7:0] got);
		fail_cnt++;
		if (fail_cnt <= MaxPrints)
			$display("%0t: clean word %0d %s mismatch, expected %h, got %h",
				$time, word_cnt, field, want, got);
	endtask

	always @(posedge clk) begin
		out_word_t want;
		if (!arst_n) begin
			clear_state();
			clean_q.delete();
		end else begin
			if ($isunknown(clean_valid))
				report("clean_valid", 8'h00, {7'h00, clean_valid});
			// compare a taken clean word with the oldest prediction
			if (clean_valid && !clean_stall) begin
				if (clean_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= MaxPrints)
						$display("%0t: clean word %0d unexpected, expected none, got %h/%b/%b",
							$time, word_cnt, clean.out_byte, clean.byte_valid,
							clean.end_of_text);
				end else begin
					want = clean_q.pop_front();
					if (clean.out_byte !== want.out_byte)
						report("out_byte", want.out_byte, clean.out_byte);
					if (clean.byte_valid !== want.byte_valid)
						report("byte_valid", want.byte_valid, clean.byte_valid);
					if (clean.end_of_text !== want.end_of_text)
						report("end_of_text", want.end_of_text, clean.end_of_text);
				end
				word_cnt++;
			end
			// predict from a taken text byte
			if (text_valid && !text_stall) begin
				predict_byte(text);
				byte_cnt++;
				if (text.last_byte)
					text_cnt++;
			end
		end
		errors      <= fail_cnt;
		outstanding <= clean_q.size();
		bytes_taken <= byte_cnt;
		words_taken <= word_cnt;
		texts_taken <= text_cnt;
	end

endmodule

@@ test/html_tag_strip_entity_decode_tb.sv @@
module html_tag_strip_entity_decode_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import htsed_pkg::*;

	localparam int         ItemTarget   = 320;
	localparam int         HoldCycles   = 80;
	localparam int         SettleCycles = 20;
	localparam logic [7:0] ChReturn     = 8'h0D;

	logic      clk;
	logic      arst_n;
	logic      text_valid;
	logic      text_stall;
	in_word_t  text;
	logic      clean_valid;
	logic      clean_stall;
	out_word_t clean;

	int errors;
	int outstanding;
	int bytes_taken;
	int words_taken;
	int texts_taken;

	logic       hold_req;
	logic [7:0] text_buf[$];
	int         sent_total;

	html_tag_strip_entity_decode dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_valid  (text_valid),
		.text_stall  (text_stall),
		.text        (text),
		.clean_valid (clean_valid),
		.clean_stall (clean_stall),
		.clean       (clean)
	);

	html_tag_strip_entity_decode_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_valid  (text_valid),
		.text_stall  (text_stall),
		.text        (text),
		.clean_valid (clean_valid),
		.clean_stall (clean_stall),
		.clean       (clean),
		.errors      (errors),
		.outstanding (outstanding),
		.bytes_taken (bytes_taken),
		.words_taken (words_taken),
		.texts_taken (texts_taken)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit, several times the slowest legal run
	initial begin
		#6_000_000;
		$display("html_tag_strip_entity_decode_tb NOT OK");
		$finish;
	end

	// idle run length: mostly short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return $urandom_range(1, 3);
		else if (r < 9)
			return $urandom_range(4, 8);
		return $urandom_range(15, 40);
	endfunction

	function automatic string entity_name(input int k);
		case (k)
			0:       return "&amp;";
			1:       return "&lt;";
			2:       return "&gt;";
			3:       return "&quot;";
			4:       return "&#39;";
			default: return "&nbsp;";
		endcase
	endfunction

	// receiver: random stall runs, one long hold on request
	initial begin
		logic held;
		logic lvl;
		int   n;
		held = 1'b0;
		clean_stall = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req && !held) begin
				held = 1'b1;
				lvl  = 1'b1;
				n    = HoldCycles;
			end else begin
				lvl = ($urandom_range(0, 3) == 0);
				if (lvl)
					n = idle_len();
				else if ($urandom_range(0, 7) == 0)
					n = $urandom_range(25, 60);
				else
					n = $urandom_range(1, 6);
			end
			clean_stall <= lvl;
			repeat (n) @(posedge clk);
		end
	end

	task automatic load_string(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
	endtask

	// offer the buffered text, one word per handshake
	task automatic send_text(input bit steady);
		in_word_t w;
		bit       stalled;
		int       i;
		int       gap;
		for (i = 0; i < text_buf.size(); i++) begin
			w.in_byte   = text_buf[i];
			w.last_byte = (i == text_buf.size() - 1);
			text_valid <= 1'b1;
			text       <= w;
			do begin
				@(negedge clk);
				stalled = text_stall;
				@(posedge clk);
			end while (stalled);
			sent_total++;
			gap = (steady || $urandom_range(0, 2) != 0) ? 0 : idle_len();
			if (gap > 0) begin
				text_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// sender waits until every predicted word has come out
	task automatic drain();
		text_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// one token of text; mostly well formed, some noise and broken pieces
	task automatic add_token(input bit noisy, input bit final_tok);
		string      s;
		logic [7:0] c;
		int         n;
		int         i;
		int         cut;
		if (noisy) begin
			case ($urandom_range(0, 2))
				0: text_buf.push_back($urandom_range(0, 1) ? ChTagClose : ChAmp);
				default: begin
					n = $urandom_range(1, 4);
					for (i = 0; i < n; i++) begin
						c = 8'($urandom_range(1, 255));
						text_buf.push_back(c);
					end
				end
			endcase
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					n = $urandom_range(1, 4);
					for (i = 0; i < n; i++) begin
						do c = 8'($urandom_range(33, 126));
						while (c == ChTagOpen || c == ChAmp);
						text_buf.push_back(c);
					end
				end
				4: begin
					n = $urandom_range(1, 3);
					for (i = 0; i < n; i++) begin
						case ($urandom_range(0, 2))
							0:       text_buf.push_back(ChSpace);
							1:       text_buf.push_back(ChTab);
							default: text_buf.push_back(ChNewline);
						endcase
					end
				end
				5, 6: load_string(entity_name($urandom_range(0, 5)));
				7: begin
					// entity cut short, then broken by another byte or by the end
					s = entity_name($urandom_range(0, 5));
					cut = $urandom_range(1, s.len() - 1);
					for (i = 0; i < cut; i++)
						text_buf.push_back(s[i]);
					if (!final_tok || $urandom_range(0, 1) == 0) begin
						c = 8'($urandom_range(1, 255));
						text_buf.push_back(c);
					end
				end
				8: begin
					// tag with random body, sometimes left open at the end
					text_buf.push_back(ChTagOpen);
					n = $urandom_range(0, 4);
					for (i = 0; i < n; i++) begin
						do c = 8'($urandom_range(1, 255));
						while (c == ChTagClose);
						text_buf.push_back(c);
					end
					if (!final_tok || $urandom_range(0, 2) != 0)
						text_buf.push_back(ChTagClose);
				end
				default: begin
					n = $urandom_range(1, 2);
					for (i = 0; i < n; i++) begin
						c = 8'($urandom_range(128, 255));
						text_buf.push_back(c);
					end
				end
			endcase
		end
	endtask

	task automatic build_text();
		int n_tok;
		int t;
		text_buf.delete();
		n_tok = $urandom_range(1, 8);
		for (t = 0; t < n_tok; t++)
			add_token($urandom_range(0, 3) == 0, t == n_tok - 1);
	endtask

	// stimulus and verdict
	initial begin
		int n_text;
		bit paused_mid;
		arst_n     = 1'b0;
		text_valid = 1'b0;
		text       = '0;
		hold_req   = 1'b0;
		sent_total = 0;
		paused_mid = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// byte 01 hex as a one byte text
		text_buf.delete();
		text_buf.push_back(8'h01);
		send_text(1'b0);
		// leading tab, decoded lt and amp stay text, text ends inside a tag
		text_buf.delete();
		text_buf.push_back(ChTab);
		load_string("&lt;&amp;<x");
		send_text(1'b1);
		// largest byte, carriage return kept, open prefix spilled at the end
		text_buf.delete();
		text_buf.push_back(8'hFF);
		text_buf.push_back(ChReturn);
		load_string("&n");
		send_text(1'b0);
		// broken nbsp after a held space, then an open amp: a full burst
		text_buf.delete();
		load_string("b &nbsp&");
		send_text(1'b1);
		drain();

		// random texts; the receiver holds off while the first ones pile up
		hold_req <= 1'b1;
		n_text = 0;
		while (sent_total < ItemTarget) begin
			build_text();
			send_text(n_text < 3 || $urandom_range(0, 4) == 0);
			n_text++;
			if (!paused_mid && sent_total >= ItemTarget / 2) begin
				paused_mid = 1'b1;
				drain();
			end
		end
		drain();
		repeat (SettleCycles) @(posedge clk);

		$display("run: %0d text bytes in %0d texts, %0d clean words checked, %0d outstanding",
			bytes_taken, texts_taken, words_taken, outstanding);
		if (errors == 0 && outstanding == 0)
			$display("html_tag_strip_entity_decode_tb OK");
		else
			$display("html_tag_strip_entity_decode_tb NOT OK");
		$finish;
	end

endmodule
